FILE: sv/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// shared types and constants of the line rasterizer: coordinate widths,
// transaction payloads and the command word between front and back
// ----------------------------------------------------------------------------
package brl_pkg;

   localparam int COORD_BITS = 12;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERROR_BITS = COORD_BITS + 4;
   localparam int COLOR_BITS = 24;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERROR_BITS-1:0] error_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      op_type    op;
      coord_type x_a;
      coord_type y_a;
      coord_type x_b;
      coord_type y_b;
      color_type line_color;
   } req_type;

   typedef struct packed {
      coord_type pix_x;
      coord_type pix_y;
      color_type pix_color;
      logic      last;
   } rsp_type;

   typedef struct packed {
      logic      is_load;
      logic      major_is_y;
      logic      minor_dir_neg;
      coord_type start_major;
      coord_type start_minor;
      delta_type delta_major;
      delta_type delta_minor;
      color_type color;
   } cmd_type;

endpackage

FILE: sv/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front
// accepts transactions, classifies load and tick, and works out the major
// axis, start point, deltas and minor direction of a new line
// ----------------------------------------------------------------------------
module brl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  brl_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_full,
   output brl_pkg::cmd_type cmd_data
);
   import brl_pkg::*;

   logic      valid_ff, valid_in;
   cmd_type   cmd_ff, cmd_in;
   logic      accept, advance;

   logic signed [DELTA_BITS-1:0] dx, dy, dmaj_s, dmin_s;
   delta_type adx, ady;
   logic      major_y, fwd;

   assign advance = valid_ff && !cmd_full;
   assign full    = valid_ff && cmd_full;
   assign accept  = push && !full;

   always_comb begin
      dx      = DELTA_BITS'(req_data.x_b) - DELTA_BITS'(req_data.x_a);
      dy      = DELTA_BITS'(req_data.y_b) - DELTA_BITS'(req_data.y_a);
      adx     = dx[DELTA_BITS-1] ? delta_type'(-dx) : delta_type'(dx);
      ady     = dy[DELTA_BITS-1] ? delta_type'(-dy) : delta_type'(dy);
      major_y = !(adx > ady);
      dmaj_s  = major_y ? dy : dx;
      dmin_s  = major_y ? dx : dy;
      fwd     = !dmaj_s[DELTA_BITS-1];

      cmd_in.is_load    = (req_data.op == OP_LOAD);
      cmd_in.major_is_y = major_y;
      cmd_in.minor_dir_neg = fwd ? dmin_s[DELTA_BITS-1]
                                 : (!dmin_s[DELTA_BITS-1] && (dmin_s != '0));
      if (major_y) begin
         cmd_in.start_major = fwd ? req_data.y_a : req_data.y_b;
         cmd_in.start_minor = fwd ? req_data.x_a : req_data.x_b;
         cmd_in.delta_major = ady;
         cmd_in.delta_minor = adx;
      end else begin
         cmd_in.start_major = fwd ? req_data.x_a : req_data.x_b;
         cmd_in.start_minor = fwd ? req_data.y_a : req_data.y_b;
         cmd_in.delta_major = adx;
         cmd_in.delta_minor = ady;
      end
      cmd_in.color = req_data.line_color;
   end

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

FILE: sv/brl_queue.sv
// ----------------------------------------------------------------------------
// brl_queue
// small command queue between front and back, register based
// ----------------------------------------------------------------------------
module brl_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  brl_pkg::cmd_type wr_data,
   output logic             q_full,
   output logic             q_valid,
   input  logic             rd_en,
   output brl_pkg::cmd_type rd_data
);
   import brl_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign q_full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && q_full && !rd_en))
      else $error("queue written while full");

   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && !q_valid))
      else $error("queue read while empty");
`endif

endmodule

FILE: sv/brl_back.sv
// ----------------------------------------------------------------------------
// brl_back
// line stepper: loads a prepared line, emits one pixel per tick while a
// line is active, and holds the pixel in an output register
// ----------------------------------------------------------------------------
module brl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  brl_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output brl_pkg::rsp_type rsp_data
);
   import brl_pkg::*;

   delta_type remain_ff, remain_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff;
   coord_type cur_major_ff, cur_minor_ff;
   delta_type dmaj_ff, dmin_ff;
   error_type err_ff, err_load, err_step;
   logic      dir_neg_ff, major_y_ff;
   color_type color_ff;

   logic      out_free, do_load, do_emit, err_pos, emit_last;
   rsp_type   pix;

   assign out_free  = !out_valid_ff || pop;
   assign cmd_pop   = cmd_valid && out_free;
   assign do_load   = cmd_pop && cmd_data.is_load;
   assign do_emit   = cmd_pop && !cmd_data.is_load && (remain_ff != '0);
   assign emit_last = (remain_ff == DELTA_BITS'(1));
   assign err_pos   = !err_ff[ERROR_BITS-1] && (err_ff != '0);

   always_comb begin
      err_load = ERROR_BITS'({cmd_data.delta_minor, 1'b0})
               - ERROR_BITS'(cmd_data.delta_major);
      err_step = err_ff + ERROR_BITS'({dmin_ff, 1'b0});
      if (err_pos) begin
         err_step = err_step - ERROR_BITS'({dmaj_ff, 1'b0});
      end
      pix.pix_x     = major_y_ff ? cur_minor_ff : cur_major_ff;
      pix.pix_y     = major_y_ff ? cur_major_ff : cur_minor_ff;
      pix.pix_color = color_ff;
      pix.last      = emit_last;
   end

   always_comb begin
      priority if (do_load) begin
         remain_in = cmd_data.delta_major;
      end else if (do_emit) begin
         remain_in = remain_ff - DELTA_BITS'(1);
      end else begin
         remain_in = remain_ff;
      end
      priority if (do_emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         cur_major_ff <= cmd_data.start_major;
         cur_minor_ff <= cmd_data.start_minor;
         dmaj_ff      <= cmd_data.delta_major;
         dmin_ff      <= cmd_data.delta_minor;
         err_ff       <= err_load;
         dir_neg_ff   <= cmd_data.minor_dir_neg;
         major_y_ff   <= cmd_data.major_is_y;
         color_ff     <= cmd_data.color;
      end else if (do_emit) begin
         cur_major_ff <= cur_major_ff + COORD_BITS'(1);
         if (err_pos) begin
            cur_minor_ff <= dir_neg_ff ? cur_minor_ff - COORD_BITS'(1)
                                       : cur_minor_ff + COORD_BITS'(1);
         end
         err_ff <= err_step;
      end
      if (do_emit) begin
         out_ff <= pix;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTHESIS
   a_remain_bounded: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> (remain_ff <= dmaj_ff))
      else $error("remaining pixel count exceeds line length");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (do_emit && emit_last) |=> (remain_ff == '0))
      else $error("line still active after last pixel");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      do_emit |=> (out_valid_ff && (out_ff.last == $past(emit_last))))
      else $error("emitted pixel not held in output register");
`endif

endmodule

FILE: sv/bresenham_line_rasterizer.sv
// path: a transaction passes the front register, a command queue entry and the
// output register; throughput: one transaction per cycle, set by the single-step
// error adder in the back stepper, while no full queue or unpopped pixel stalls it;
// loads and ticks with no active line give no pixel
// reset: synchronous, clears the queue, valid flags and the active line;
// no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// integer line stepper with decoupled classify front and stepping back end
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  brl_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output brl_pkg::rsp_type rsp_data
);
   import brl_pkg::*;

   logic    front_valid, q_full, q_valid, q_pop;
   cmd_type front_cmd, q_cmd;

   brl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_full  (q_full),
      .cmd_data  (front_cmd)
   );

   brl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid && !q_full),
      .wr_data (front_cmd),
      .q_full  (q_full),
      .q_valid (q_valid),
      .rd_en   (q_pop),
      .rd_data (q_cmd)
   );

   brl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_cmd),
      .cmd_pop   (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/bresenham_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb
// Self-checking bench for the line rasterizer. A directed table covers reset,
// coordinate extremes, equal slopes, reversed endpoints, zero-length lines,
// ignored ticks and a line replaced mid-way. Random lines follow, mostly short
// ones anywhere on the grid, plus long ones cut off early and stray
// transactions. Every pixel is checked against a cycle-free line stepper kept
// in the bench, with random gaps on both queue sides.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;

   import brl_pkg::*;

   localparam int NUM_ITEMS   = 1950;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_SHOWN   = 10;
   localparam rsp_type NO_PIX = '0;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type pix;
   } vec_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   // line stepper state
   int        cur_maj;
   int        cur_min;
   int        end_maj;
   int        d_maj;
   int        d_min;
   int        err_acc;
   bit        min_neg;
   bit        maj_y;
   bit        line_on;
   color_type held_col;

   rsp_type     pixel_q[$];
   vec_row_type vec_tab[25];
   bit          gaps_on = 1'b1;
   int          n_errors;
   int          n_items;
   int          n_loads;
   int          n_checked;
   int          n_last;
   int          stall_cnt;

   bresenham_line_rasterizer i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_type mkreq(op_type op, int xa, int ya, int xb, int yb, int col);
      req_type r;
      r.op         = op;
      r.x_a        = COORD_BITS'(xa);
      r.y_a        = COORD_BITS'(ya);
      r.x_b        = COORD_BITS'(xb);
      r.y_b        = COORD_BITS'(yb);
      r.line_color = COLOR_BITS'(col);
      return r;
   endfunction

   function automatic rsp_type mkpix(int x, int y, int col, bit fin);
      rsp_type p;
      p.pix_x     = COORD_BITS'(x);
      p.pix_y     = COORD_BITS'(y);
      p.pix_color = COLOR_BITS'(col);
      p.last      = fin;
      return p;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp_coord(int v);
      return (v > 2047) ? 2047 : (v < -2048) ? -2048 : v;
   endfunction

   function automatic req_type rand_req(op_type op);
      return mkreq(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   int'($urandom_range(24'hFFFFFF)));
   endfunction

   // one transaction through the line stepper
   function automatic void rasterize_step(input req_type r, output bit got, output rsp_type pix);
      int xa, ya, xb, yb, adx, ady, s_maj, s_min, e_min, dmin;
      bit fin;
      got = 1'b0;
      pix = '0;
      if (r.op == OP_LOAD) begin
         xa = r.x_a;
         ya = r.y_a;
         xb = r.x_b;
         yb = r.y_b;
         adx = (xb >= xa) ? xb - xa : xa - xb;
         ady = (yb >= ya) ? yb - ya : ya - yb;
         held_col = r.line_color;
         maj_y = !(adx > ady);
         if (!maj_y) begin
            if (xa <= xb) begin
               s_maj = xa; s_min = ya; end_maj = xb; e_min = yb;
            end else begin
               s_maj = xb; s_min = yb; end_maj = xa; e_min = ya;
            end
         end else begin
            if (ya <= yb) begin
               s_maj = ya; s_min = xa; end_maj = yb; e_min = xb;
            end else begin
               s_maj = yb; s_min = xb; end_maj = ya; e_min = xa;
            end
         end
         dmin    = e_min - s_min;
         min_neg = dmin < 0;
         d_min   = min_neg ? -dmin : dmin;
         d_maj   = end_maj - s_maj;
         cur_maj = s_maj;
         cur_min = s_min;
         err_acc = 2 * d_min - d_maj;
         line_on = cur_maj < end_maj;
      end else if (line_on) begin
         fin = (cur_maj + 1) >= end_maj;
         got = 1'b1;
         pix = mkpix(maj_y ? cur_min : cur_maj, maj_y ? cur_maj : cur_min, held_col, fin);
         if (err_acc > 0) begin
            cur_min += min_neg ? -1 : 1;
            err_acc -= 2 * d_maj;
         end
         err_acc += 2 * d_min;
         cur_maj += 1;
         if (fin) line_on = 1'b0;
      end
   endfunction

   task automatic drive_item(input req_type r, input bit typed = 1'b0,
                             input rsp_type typed_pix = '0);
      bit      got;
      rsp_type pix;
      while (gaps_on && $urandom_range(99) < 19) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      rasterize_step(r, got, pix);
      if (typed) pixel_q.push_back(typed_pix);
      else if (got) pixel_q.push_back(pix);
      if (r.op == OP_LOAD) n_loads++;
      n_items++;
   endtask

   task automatic hold_until_drained();
      push <= 1'b0;
      do @(posedge clock); while (pixel_q.size() != 0);
   endtask

   task automatic draw_random_line();
      int pick, span, x0, y0, x1, y1, col, remaining, ticks;
      pick = $urandom_range(99);
      span = (pick < 5) ? 4095 : (pick < 10) ? 0 : $urandom_range(20, 1);
      col  = $urandom_range(24'hFFFFFF);
      x0   = rand_coord();
      y0   = rand_coord();
      if ($urandom_range(9) == 0) begin
         x0 = $urandom_range(1) ? 2047 : -2048;
         y0 = $urandom_range(1) ? 2047 : -2048;
      end
      if (span == 4095) begin
         x1 = rand_coord();
         y1 = rand_coord();
      end else begin
         x1 = clamp_coord(x0 + int'($urandom_range(2 * span)) - span);
         y1 = clamp_coord(y0 + int'($urandom_range(2 * span)) - span);
      end
      drive_item(mkreq(OP_LOAD, x0, y0, x1, y1, col));
      remaining = line_on ? end_maj - cur_maj : 0;
      if (remaining > 40) ticks = $urandom_range(30, 1);
      else if (remaining > 0 && $urandom_range(99) < 15) ticks = $urandom_range(remaining - 1);
      else ticks = remaining + (($urandom_range(3) == 0) ? 1 : 0);
      repeat (ticks) drive_item(rand_req(OP_TICK));
   endtask

   task automatic check_pixel(input rsp_type got);
      rsp_type want;
      n_checked++;
      if (got.last) n_last++;
      if (pixel_q.size() == 0) begin
         if (n_errors < MAX_SHOWN)
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $realtime,
                     got.pix_x, got.pix_y, got.pix_color, got.last);
         n_errors++;
      end else begin
         want = pixel_q.pop_front();
         if (got.pix_x != want.pix_x || got.pix_y != want.pix_y ||
             got.pix_color != want.pix_color || got.last != want.last) begin
            if (n_errors < MAX_SHOWN)
               $display("%0t: pixel mismatch exp x=%0d y=%0d color=%h last=%b,",
                        $realtime, want.pix_x, want.pix_y, want.pix_color, want.last,
                        " got x=%0d y=%0d color=%h last=%b",
                        got.pix_x, got.pix_y, got.pix_color, got.last);
            n_errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_pixel(rsp_data);
         pop <= !(gaps_on && $urandom_range(99) < 19);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d pixels outstanding", $realtime,
                     STALL_LIMIT, pixel_q.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int next_hold;
      vec_tab = '{
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b0, NO_PIX},
         '{mkreq(OP_LOAD, 0, 0, 3, 0, 24'hFFFFFF), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(0, 0, 24'hFFFFFF, 1'b0)},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(1, 0, 24'hFFFFFF, 1'b0)},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(2, 0, 24'hFFFFFF, 1'b1)},
         '{mkreq(OP_TICK, -1, -1, -1, -1, 24'hFFFFFF), 1'b0, NO_PIX},
         '{mkreq(OP_LOAD, 5, 5, 5, 5, 24'h123456), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b0, NO_PIX},
         '{mkreq(OP_LOAD, -2048, -2048, 2047, 2047, 0), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(-2048, -2048, 0, 1'b0)},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(-2047, -2047, 0, 1'b0)},
         '{mkreq(OP_LOAD, 2047, -2048, -2048, 2047, 24'h800001), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(2047, -2048, 24'h800001, 1'b0)},
         '{mkreq(OP_LOAD, 2047, 0, -2048, 1, 24'h00FF00), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(-2048, 1, 24'h00FF00, 1'b0)},
         '{mkreq(OP_LOAD, 2047, 2047, 2044, 2047, 24'hA5A5A5), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(2044, 2047, 24'hA5A5A5, 1'b0)},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(2045, 2047, 24'hA5A5A5, 1'b0)},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b1, mkpix(2046, 2047, 24'hA5A5A5, 1'b1)},
         '{mkreq(OP_LOAD, 0, 0, 1, 3, 24'h0F0F0F), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, -1, -1, -1, -1, 24'hFFFFFF), 1'b0, NO_PIX},
         '{mkreq(OP_LOAD, 10, -3, 7, -3, 24'hF0F0F0), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, -2048, 2047, -2048, 2047, 24'h555555), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b0, NO_PIX},
         '{mkreq(OP_TICK, 0, 0, 0, 0, 0), 1'b0, NO_PIX}
      };
      cur_maj  = 0;
      cur_min  = 0;
      end_maj  = 0;
      d_maj    = 0;
      d_min    = 0;
      err_acc  = 0;
      min_neg  = 1'b0;
      maj_y    = 1'b0;
      line_on  = 1'b0;
      held_col = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (vec_tab[i]) drive_item(vec_tab[i].req, vec_tab[i].typed, vec_tab[i].pix);
      hold_until_drained();

      next_hold = 400;
      while (n_items < NUM_ITEMS) begin
         // no gaps on either side for a while
         gaps_on = !(n_items >= 700 && n_items < 1000);
         if (n_items >= next_hold) begin
            hold_until_drained();
            next_hold += 400;
         end
         if ($urandom_range(99) < 5) drive_item(rand_req($urandom_range(1) ? OP_TICK : OP_LOAD));
         else draw_random_line();
      end
      gaps_on = 1'b1;
      push <= 1'b0;

      while (pixel_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d line loads and %0d transactions sent, %0d pixels checked (%0d line ends)",
               n_loads, n_items, n_checked, n_last);
      $display("%0d mismatches, %0d pixels still outstanding", n_errors, pixel_q.size());
      if (n_errors == 0 && pixel_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
